// ===== hw/rtl/base64_block_codec_assert.svh =====
// Assertion macros shared by the codec RTL.
`ifndef BASE64_BLOCK_CODEC_ASSERT_SVH
`define BASE64_BLOCK_CODEC_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define B64_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("base64 codec check failed");

// Next-cycle implication, checked out of reset.
`define B64_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("base64 codec check failed");

`endif

// ===== hw/rtl/b64bc_pkg.sv =====
`default_nettype none

package b64bc_pkg;

    localparam int NUM_LANES = 4;
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic [7:0] enc_char;
        logic [5:0] sym;
        logic       is_pad;
        logic       is_bad;
    } t_lane;

    typedef struct packed {
        logic [7:0] out_a;
        logic [7:0] out_b;
        logic [7:0] out_c;
        logic [7:0] out_d;
        logic [2:0] out_count;
        logic       bad_char;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/b64bc_lane.sv =====
`default_nettype none

module b64bc_lane
    import b64bc_pkg::*;
(
    input  wire logic [7:0] i_char,
    input  wire logic [5:0] i_sextet,
    output t_lane           o_lane
);

    logic [7:0] w_dec;
    logic       w_bad;

    always_comb begin
        w_bad = 1'b0;
        w_dec = 8'd0;
        if (i_char >= 8'h41 && i_char <= 8'h5A) begin
            w_dec = i_char - 8'h41;
        end else if (i_char >= 8'h61 && i_char <= 8'h7A) begin
            w_dec = i_char - 8'h61 + 8'd26;
        end else if (i_char >= 8'h30 && i_char <= 8'h39) begin
            w_dec = i_char - 8'h30 + 8'd52;
        end else if (i_char == 8'h2B) begin
            w_dec = 8'd62;
        end else if (i_char == 8'h2F) begin
            w_dec = 8'd63;
        end else begin
            w_bad = 1'b1;
        end
    end

    always_comb begin
        o_lane.is_pad = (i_char == PAD_CHAR);
        o_lane.is_bad = w_bad && (i_char != PAD_CHAR);
        o_lane.sym    = w_dec[5:0];
        if (i_sextet < 6'd26) begin
            o_lane.enc_char = 8'h41 + {2'b00, i_sextet};
        end else if (i_sextet < 6'd52) begin
            o_lane.enc_char = 8'h61 + {2'b00, i_sextet} - 8'd26;
        end else if (i_sextet < 6'd62) begin
            o_lane.enc_char = 8'h30 + {2'b00, i_sextet} - 8'd52;
        end else if (i_sextet == 6'd62) begin
            o_lane.enc_char = 8'h2B;
        end else begin
            o_lane.enc_char = 8'h2F;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64bc_merge.sv =====
`default_nettype none

module b64bc_merge
    import b64bc_pkg::*;
(
    input  wire t_lane   i_lane [NUM_LANES],
    input  wire logic    i_dir,
    input  wire logic    i_has_b,
    input  wire logic    i_has_c,
    output t_result      o_res
);

    logic [23:0] w_acc;
    logic [2:0]  w_kept;
    logic        w_bad;

    always_comb begin
        w_acc  = 24'd0;
        w_kept = 3'd0;
        w_bad  = 1'b0;
        for (int i = 0; i < NUM_LANES; i++) begin
            if (!i_lane[i].is_pad) begin
                w_acc  = {w_acc[17:0], i_lane[i].sym};
                w_kept = w_kept + 3'd1;
                w_bad  = w_bad | i_lane[i].is_bad;
            end
        end
    end

    always_comb begin
        o_res = '0;
        if (!i_dir) begin
            o_res.out_a     = i_lane[0].enc_char;
            o_res.out_b     = i_lane[1].enc_char;
            o_res.out_c     = i_has_b ? i_lane[2].enc_char : PAD_CHAR;
            o_res.out_d     = i_has_c ? i_lane[3].enc_char : PAD_CHAR;
            o_res.out_count = 3'd4;
        end else if (w_bad) begin
            o_res.bad_char = 1'b1;
        end else begin
            case (w_kept)
                3'd4: begin
                    o_res.out_a     = w_acc[23:16];
                    o_res.out_b     = w_acc[15:8];
                    o_res.out_c     = w_acc[7:0];
                    o_res.out_count = 3'd3;
                end
                3'd3: begin
                    o_res.out_a     = w_acc[17:10];
                    o_res.out_b     = w_acc[9:2];
                    o_res.out_count = 3'd2;
                end
                3'd2: begin
                    o_res.out_a     = w_acc[11:4];
                    o_res.out_count = 3'd1;
                end
                default: begin
                    o_res.out_count = 3'd0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/base64_block_codec.sv =====
// Base64 block codec, one four-symbol block per transaction.
// Each transaction passes the lane stage, then the merge stage, before its result is presented.
// Throughput: one transaction per cycle; the two-stage pipeline stalls only on output backpressure.
// Reset (synchronous, active low) empties the pipeline and sets the direction to encode.
`default_nettype none

`include "base64_block_codec_assert.svh"

module base64_block_codec
    import b64bc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wen,
    input  wire logic        i_cfg_wdata,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // in_a [7:0], in_b [15:8], in_c [23:16], in_d [31:24], byte_count [33:32].
    input  wire logic [39:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // out_a [7:0], out_b [15:8], out_c [23:16], out_d [31:24], out_count [34:32].
    output logic [39:0]      o_m_axis_tdata,
    // bad_char [0].
    output logic [0:0]       o_m_axis_tuser
);

    logic       r_dir;
    logic       r_v1;
    logic       r_v2;
    logic       r_dir1;
    logic       r_has_b1;
    logic       r_has_c1;
    logic       r_dir2;
    t_lane      r_lane [NUM_LANES];
    t_result    r_res;

    logic       w_adv1;
    logic       w_adv2;
    logic [7:0] w_a;
    logic [7:0] w_b;
    logic [7:0] w_c;
    logic [1:0] w_cnt;
    logic       w_has_b;
    logic       w_has_c;
    logic [7:0] w_chars   [NUM_LANES];
    logic [5:0] w_sextets [NUM_LANES];
    t_lane      w_lane    [NUM_LANES];
    t_result    w_res;

    assign w_adv2 = !r_v2 || i_m_axis_tready;
    assign w_adv1 = !r_v1 || w_adv2;
    assign o_s_axis_tready = w_adv1;

    assign w_cnt   = i_s_axis_tdata[33:32];
    assign w_has_b = w_cnt[1];
    assign w_has_c = (w_cnt == 2'd3);
    assign w_a     = i_s_axis_tdata[7:0];
    assign w_b     = w_has_b ? i_s_axis_tdata[15:8] : 8'd0;
    assign w_c     = w_has_c ? i_s_axis_tdata[23:16] : 8'd0;

    assign w_sextets[0] = w_a[7:2];
    assign w_sextets[1] = {w_a[1:0], w_b[7:4]};
    assign w_sextets[2] = {w_b[3:0], w_c[7:6]};
    assign w_sextets[3] = w_c[5:0];

    assign w_chars[0] = i_s_axis_tdata[7:0];
    assign w_chars[1] = i_s_axis_tdata[15:8];
    assign w_chars[2] = i_s_axis_tdata[23:16];
    assign w_chars[3] = i_s_axis_tdata[31:24];

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        b64bc_lane u_lane (
            .i_char   (w_chars[g]),
            .i_sextet (w_sextets[g]),
            .o_lane   (w_lane[g])
        );
    end

    b64bc_merge u_merge (
        .i_lane  (r_lane),
        .i_dir   (r_dir1),
        .i_has_b (r_has_b1),
        .i_has_c (r_has_c1),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_dir <= i_cfg_wdata;
            end
            if (w_adv1) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_s_axis_tvalid) begin
            r_lane   <= w_lane;
            r_dir1   <= r_dir;
            r_has_b1 <= w_has_b;
            r_has_c1 <= w_has_c;
        end
        if (w_adv2 && r_v1) begin
            r_res  <= w_res;
            r_dir2 <= r_dir1;
        end
    end

    assign o_m_axis_tvalid = r_v2;
    assign o_m_axis_tdata  = {5'd0, r_res.out_count, r_res.out_d, r_res.out_c,
                              r_res.out_b, r_res.out_a};
    assign o_m_axis_tuser  = r_res.bad_char;

    `B64_ASSERT_IMP(a_enc_shape, i_clk, i_rst_n, r_v2 && !r_dir2,
        r_res.out_count == 3'd4 && !r_res.bad_char)
    `B64_ASSERT_IMP(a_dec_shape, i_clk, i_rst_n, r_v2 && r_dir2,
        r_res.out_count <= 3'd3 && r_res.out_d == 8'd0)
    `B64_ASSERT_IMP(a_bad_zero, i_clk, i_rst_n, r_v2 && r_res.bad_char,
        r_res.out_count == 3'd0 && r_res.out_a == 8'd0 && r_res.out_b == 8'd0)
    `B64_ASSERT_NXT(a_pipe_move, i_clk, i_rst_n, r_v1 && w_adv2, r_v2)

endmodule

`default_nettype wire
